@@ src/bffra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffra_pkg
// Shared types and constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package bffra_pkg;

  // bitmap is walked one word at a time
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;
  localparam int POS_W  = 9;
  localparam int WIDX_W = POS_W - BIT_W;

  // request modes
  localparam logic [1:0] MODE_FIND = 2'd0;
  localparam logic [1:0] MODE_MARK = 2'd1;
  localparam logic [1:0] MODE_FREE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // register map
  localparam logic       REG_ACTIVE_BITS = 1'b0;
  localparam logic [8:0] ACTIVE_BITS_RST = 9'd256;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request fields
    logic setup;  // range check, first word read
    logic scan;   // evaluate current word, fetch next
    logic emit;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_err;
    logic found;
    logic last_word;
  } sts_t;

endpackage

@@ src/bffra_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffra_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bffra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bffra_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffra_dp
// Datapath: request registers, range check, bitmap word store with per-word
// valid bits, word-at-a-time run search and read-modify-write of ranges.
// ----------------------------------------------------------------------------
module bffra_dp import bffra_pkg::*; #(
  parameter int SLOT_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output logic [8:0] active_bits,
  input  logic [1:0] mode,
  input  logic [8:0] start_req,
  input  logic [8:0] region_size,
  output logic [1:0] status,
  output logic [7:0] position
);

  localparam int WORDS = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int N_CAP = (SLOT_COUNT > 511) ? 511 : SLOT_COUNT;

  logic [8:0]        act_bits;
  logic [1:0]        req_mode;
  logic [8:0]        req_start;
  logic [8:0]        req_size;
  logic [WIDX_W-1:0] cur_idx;
  logic [8:0]        carry;
  logic [1:0]        res_status;
  logic [7:0]        res_pos;
  logic [WORDS-1:0]  wvalid;
  logic              rd_valid;

  logic [8:0]        n;
  logic [9:0]        avail;
  logic [9:0]        req_end;
  logic [9:0]        last_pos;
  logic              is_find;
  logic              range_err;
  logic [WIDX_W-1:0] rd_idx;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] word;
  logic [8:0]        base;
  logic [WORD_W-1:0] in_win;
  logic [WORD_W-1:0] in_rng;
  logic [WORD_W-1:0] free;
  logic [4:0]        lead;
  logic [4:0]        top;
  logic [9:0]        run_sum;
  logic              hit_carry;
  logic [WORD_W-1:0] sz_mask;
  logic [WORD_W-1:0] fit;
  logic [3:0]        fit_k;
  logic              found;
  logic [8:0]        pos_f;
  logic [8:0]        carry_next;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  // effective bitmap size and range check
  assign n         = (act_bits > 9'(N_CAP)) ? 9'(N_CAP) : act_bits;
  assign avail     = {1'b0, n} - {1'b0, req_start};
  assign req_end   = {1'b0, req_start} + {1'b0, req_size};
  assign is_find   = (req_mode == MODE_FIND);
  assign range_err = (req_mode != MODE_FIND && req_mode != MODE_MARK && req_mode != MODE_FREE)
                     || (req_size == 9'd0) || (req_start > n)
                     || ({1'b0, req_size} > avail);
  assign last_pos  = is_find ? ({1'b0, n} - 10'd1) : (req_end - 10'd1);

  // word store
  assign rd_idx = cmd.setup ? req_start[8:BIT_W] : (cur_idx + 1'b1);

  bffra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(cur_idx)),
    .wdata (wr_data),
    .raddr (AW'(rd_idx)),
    .rdata (rd_data)
  );

  // unwritten words read as free
  assign word = rd_valid ? rd_data : '0;
  assign base = {cur_idx, {BIT_W{1'b0}}};

  // per-bit window and range masks
  always_comb begin
    logic [9:0] p;
    for (int j = 0; j < WORD_W; j++) begin
      p         = {1'b0, base} + 10'(j);
      in_win[j] = (p >= {1'b0, req_start}) && (p < {1'b0, n});
      in_rng[j] = (p >= {1'b0, req_start}) && (p < req_end);
    end
  end

  assign free = ~word & in_win;

  // free run from bit 0 upward and from the top bit downward
  always_comb begin
    lead = 5'(WORD_W);
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!free[j]) lead = 5'(j);
    end
    top = 5'(WORD_W);
    for (int j = 0; j < WORD_W; j++) begin
      if (!free[j]) top = 5'(WORD_W - 1 - j);
    end
  end

  // run carried in from earlier words completes here
  assign run_sum   = {1'b0, carry} + 10'(lead);
  assign hit_carry = (run_sum >= {1'b0, req_size});

  // short runs lying wholly inside this word
  assign sz_mask = (req_size >= 9'(WORD_W)) ? '1
                   : WORD_W'((17'd1 << req_size[BIT_W-1:0]) - 17'd1);

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      fit[k] = (10'(k) + {1'b0, req_size} <= 10'(WORD_W))
               && (((free >> k) & sz_mask) == sz_mask);
    end
    fit_k = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (fit[k]) fit_k = 4'(k);
    end
  end

  assign found      = is_find && (hit_carry || (|fit));
  assign pos_f      = hit_carry ? (base - carry) : (base + 9'(fit_k));
  assign carry_next = (&free) ? (carry + 9'(WORD_W)) : 9'(top);

  // mark or free write-back
  assign wr_en   = cmd.scan && !is_find;
  assign wr_data = (req_mode == MODE_MARK) ? (word | in_rng) : (word & ~in_rng);

  assign sts.range_err = range_err;
  assign sts.found     = found;
  assign sts.last_word = (cur_idx == last_pos[8:BIT_W]);
  assign active_bits   = act_bits;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_bits <= ACTIVE_BITS_RST;
      wvalid   <= '0;
    end else begin
      if (cfg_we) act_bits <= cfg_wdata;
      if (wr_en)  wvalid[AW'(cur_idx)] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_valid <= wvalid[AW'(rd_idx)];
    if (cmd.load) begin
      req_mode  <= mode;
      req_start <= start_req;
      req_size  <= region_size;
    end
    if (cmd.setup) begin
      cur_idx    <= req_start[8:BIT_W];
      carry      <= '0;
      res_status <= ST_RANGE;
      res_pos    <= '0;
    end
    if (cmd.scan) begin
      cur_idx    <= cur_idx + 1'b1;
      carry      <= carry_next;
      res_status <= found ? ST_OK : (is_find ? ST_NOT_FOUND : ST_OK);
      res_pos    <= found ? pos_f[7:0] : 8'd0;
    end
    if (cmd.emit) begin
      status   <= res_status;
      position <= res_pos;
    end
  end

endmodule

@@ src/bffra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffra_ctrl
// Controller: request sequencing over the bitmap words and the result
// output register handshake.
// ----------------------------------------------------------------------------
module bffra_ctrl import bffra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;
  logic   out_valid_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.range_err ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.last_word) state_next = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to drain
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SETUP))
    else $error("accepted request did not enter setup");

  a_range_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && sts.range_err) |=> (state == S_RESULT))
    else $error("range error did not go straight to result");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.last_word) |=> (state == S_RESULT))
    else $error("scan ran past the last word");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && out_valid && out_stall) |=> (state == S_RESULT && out_valid))
    else $error("result overwrote a stalled output");
`endif

endmodule

@@ src/bitmap_first_fit_range_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_range_allocator_unit
// First-fit allocator over an occupancy bitmap: find a free run, mark or
// free a range; register port for the active bitmap size.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid, in_stall, mode, start_req,      | in
//           | region_size                               |
//  result   | out_valid, out_stall, status, position    | out
//  register | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
//
// A request visits k of the 16-bit bitmap words (at most 16 for a 256-slot
// bitmap); a range error skips the scan. The word store's single read and
// write port sets one word per cycle. Synchronous reset frees every slot
// through per-word valid bits, no sweep. A stalled result holds the unit in
// its result state; the next request is taken as soon as the result sits in
// the output register.
// ----------------------------------------------------------------------------
module bitmap_first_fit_range_allocator_unit import bffra_pkg::*; #(
  parameter int SLOT_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [8:0]  start_req,
  input  logic [8:0]  region_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  position
);

  cmd_t       cmd;
  sts_t       sts;
  logic       reg_hit;
  logic       cfg_we;
  logic [8:0] active_bits;

  // register decode
  assign reg_hit = (paddr == {REG_ACTIVE_BITS, 2'b00});
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {23'd0, active_bits} : 32'd0;

  bffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bffra_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[8:0]),
    .active_bits (active_bits),
    .mode        (mode),
    .start_req   (start_req),
    .region_size (region_size),
    .status      (status),
    .position    (position)
  );

endmodule

@@ verif/tb_bitmap_first_fit_range_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_fit_range_allocator_unit
// Self-checking bench for the first-fit range allocator. A tracker class keeps
// its own copy of the occupancy bitmap and active size, predicts the status
// and position of every accepted request and compares each result in order.
// A short directed run is followed by random requests over several active
// sizes, with idle and stall patterns on both channels and a long result
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_range_allocator_unit;
  import bffra_pkg::*;

  localparam int SLOTS         = 256;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_PHASE    = 4;
  localparam int PHASES        = 9;
  localparam int IDLE_HEAVY    = 67;
  localparam int IDLE_BOTH     = 34;

  localparam logic [1:0] MODE_UNUSED      = 2'd3;
  localparam logic [2:0] ADDR_ACTIVE_BITS = {REG_ACTIVE_BITS, 2'b00};

  // --------------------------------------------------------------------------
  // Tracker: bitmap copy, expected results queue and result checking
  // --------------------------------------------------------------------------
  class alloc_tracker;
    logic [SLOTS-1:0] occupied;
    logic [8:0]       active_bits;
    logic [1:0]       want_status[$];
    logic [7:0]       want_position[$];
    int               errors;
    int               requests;
    int               results;
    int               found;
    int               missed;
    int               rejected;

    function new();
      occupied    = '0;
      active_bits = ACTIVE_BITS_RST;
      errors      = 0;
      requests    = 0;
      results     = 0;
      found       = 0;
      missed      = 0;
      rejected    = 0;
    endfunction

    function void set_active_bits(logic [8:0] value);
      active_bits = value;
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    // work out the outcome of one accepted request and update the bitmap
    function void note_request(logic [1:0] md, logic [8:0] st, logic [8:0] sz);
      int         n;
      int         first;
      int         run;
      int         s;
      int         z;
      logic [1:0] exp_status;
      logic [7:0] exp_position;
      n            = (int'(active_bits) > SLOTS) ? SLOTS : int'(active_bits);
      s            = int'(st);
      z            = int'(sz);
      first        = 0;
      run          = 0;
      exp_status   = ST_OK;
      exp_position = '0;
      requests++;
      if (!(md inside {MODE_FIND, MODE_MARK, MODE_FREE}) || z == 0 || s > n || z > n - s) begin
        exp_status = ST_RANGE;
        rejected++;
      end else if (md == MODE_FIND) begin
        // an occupied slot restarts the run
        exp_status = ST_NOT_FOUND;
        for (int i = s; i < n; i++) begin
          if (occupied[i]) begin
            run = 0;
          end else begin
            if (run == 0) first = i;
            run++;
            if (run == z) begin
              exp_status   = ST_OK;
              exp_position = first[7:0];
              break;
            end
          end
        end
        if (exp_status == ST_OK) found++;
        else missed++;
      end else begin
        for (int i = s; i < s + z; i++) occupied[i] = (md == MODE_MARK);
      end
      want_status   = {want_status, exp_status};
      want_position = {want_position, exp_position};
    endfunction

    function void check_result(logic [1:0] got_status, logic [7:0] got_position);
      logic [1:0] exp_status;
      logic [7:0] exp_position;
      if (want_status.size() == 0) begin
        $error("result with nothing pending: status %0d position %0d",
               got_status, got_position);
        errors++;
        return;
      end
      exp_status   = want_status.pop_front();
      exp_position = want_position.pop_front();
      results++;
      if (got_status !== exp_status) begin
        $error("status: expected %0d, got %0d", exp_status, got_status);
        errors++;
      end
      if (got_position !== exp_position) begin
        $error("position: expected %0d, got %0d", exp_position, got_position);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and unit
  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  mode        = MODE_FIND;
  logic [8:0]  start_req   = '0;
  logic [8:0]  region_size = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  status;
  logic [7:0]  position;

  alloc_tracker sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycles         = 0;
  int cur_active     = int'(ACTIVE_BITS_RST);

  // register settings per phase: extremes, oversize and a few in between
  int phase_bits[PHASES]  = '{1, 0, 511, 16, 100, 255, 200, 256, 37};
  int phase_items[PHASES] = '{60, 40, 280, 150, 240, 240, 220, 300, 150};

  bitmap_first_fit_range_allocator_unit #(
    .SLOT_COUNT (SLOTS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .start_req   (start_req),
    .region_size (region_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .position    (position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bitmap_first_fit_range_allocator_unit: FAIL");
      $finish;
    end
  end

  // result side: check accepted results, then choose the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, position);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // offer one request after a random gap and wait for it to be taken
  task automatic send_request(logic [1:0] md, logic [8:0] st, logic [8:0] sz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    start_req   <= st;
    region_size <= sz;
    do @(posedge clk); while (in_stall);
    sb.note_request(md, st, sz);
  endtask

  // stop offering and wait for every pending result, then let the unit settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the active size, then read it back
  task automatic write_active_bits(int value);
    logic [8:0] v;
    v = 9'(value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_BITS;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_active_bits(v);
    cur_active = int'(v);
    // read setup follows straight on
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[8:0] !== v) begin
      $error("active_bits readback: expected %0d, got %0d", v, prdata[8:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly well-formed requests inside the active size, the rest noise
  task automatic draw_request(output logic [1:0] md, output logic [8:0] st,
                              output logic [8:0] sz);
    int n;
    int pick;
    int room;
    int cap;
    n    = (cur_active > SLOTS) ? SLOTS : cur_active;
    pick = $urandom_range(0, 99);
    if (n == 0 || pick < 12) begin
      md = 2'($urandom_range(0, 3));
      if (pick < 6 || n == 0) begin
        st = 9'($urandom);
        sz = 9'($urandom);
      end else begin
        // near the range limits: zero size, runs up to two past the end
        st = 9'($urandom_range(0, n));
        sz = 9'($urandom_range(0, n - int'(st) + 2));
      end
    end else begin
      pick = $urandom_range(0, 99);
      md   = (pick < 45) ? MODE_FIND : (pick < 75) ? MODE_MARK : MODE_FREE;
      if (md == MODE_FIND && $urandom_range(0, 2) == 0) st = '0;
      else st = 9'($urandom_range(0, n - 1));
      room = n - int'(st);
      cap  = (room < 12) ? room : 12;
      if ($urandom_range(0, 9) == 0) sz = 9'($urandom_range(1, room));
      else sz = 9'($urandom_range(1, cap));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] md;
    logic [8:0] st;
    logic [8:0] sz;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset size
    send_request(MODE_FIND, 9'd0, 9'd1);
    send_request(MODE_FIND, 9'd0, 9'd256);
    send_request(MODE_MARK, 9'd0, 9'd256);
    send_request(MODE_FIND, 9'd0, 9'd1);
    send_request(MODE_FREE, 9'd0, 9'd256);
    send_request(MODE_MARK, 9'd10, 9'd5);
    // run broken by an occupied slot must restart past it
    send_request(MODE_FIND, 9'd8, 9'd4);
    send_request(MODE_FIND, 9'd0, 9'd10);
    send_request(MODE_MARK, 9'd255, 9'd1);
    send_request(MODE_FIND, 9'd250, 9'd6);
    // range errors: zero size, start past the end, run past the end, unused mode
    send_request(MODE_MARK, 9'd3, 9'd0);
    send_request(MODE_FIND, 9'd257, 9'd1);
    send_request(MODE_FREE, 9'd256, 9'd1);
    send_request(MODE_MARK, 9'd200, 9'd57);
    send_request(MODE_UNUSED, 9'd0, 9'd1);
    send_request(MODE_FIND, 9'd511, 9'd511);
    send_request(MODE_FREE, 9'd0, 9'd256);
    send_request(MODE_FIND, 9'd255, 9'd1);
    finish_phase();

    // random requests per register setting and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      write_active_bits(phase_bits[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = IDLE_HEAVY;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = IDLE_HEAVY;
        end
        default: begin
          send_idle_pct  = IDLE_BOTH;
          recv_stall_pct = IDLE_BOTH;
        end
      endcase
      // long result hold-off so the unit backs up and stalls requests
      if (p == HOLD_PHASE) hold_left = HOLD_CYCLES;
      for (int k = 0; k < phase_items[p]; k++) begin
        draw_request(md, st, sz);
        send_request(md, st, sz);
      end
      finish_phase();
    end

    $display("summary: %0d requests over %0d phases, %0d results checked",
             sb.requests, PHASES + 1, sb.results);
    $display("summary: %0d runs found, %0d searches without a run, %0d range errors",
             sb.found, sb.missed, sb.rejected);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_bitmap_first_fit_range_allocator_unit: PASS");
    end else begin
      $display("tb_bitmap_first_fit_range_allocator_unit: FAIL");
    end
    $finish;
  end

endmodule
